/* rtl/sgf_pkg.sv */
// Shared types and constants for the single-pixel gap fill core.
package sgf_pkg;

   // CSR register indexes
   localparam int CSR_INDEX_BITS = 2;
   localparam int CSR_DATA_BITS  = 12;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_WIDTH  = 2'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_FRAME_HEIGHT = 2'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_AVERAGE_MODE = 2'd2;

   // frame geometry
   localparam int DIM_BITS     = 12;
   localparam int RESET_WIDTH  = 640;
   localparam int RESET_HEIGHT = 480;
   localparam int MIN_DIM      = 3;

   // result queue sizing
   localparam int QUEUE_DEPTH      = 8;
   localparam int QUEUE_PTR_BITS   = 3;
   localparam int QUEUE_COUNT_BITS = 4;

   // control carried from the address stage to the fill stage
   typedef struct packed {
      logic valid;
      logic has_prev_row;
      logic interior;
      logic last_row;
      logic row_end;
      logic average_mode;
   } fill_ctl_type;

   // sideband flags of one result transaction
   typedef struct packed {
      logic last_of_run;
      logic frame_end;
   } rsp_flags_type;

endpackage

/* rtl/sgf_row_store.sv */
// Line buffers: original row (two read ports) and processed row, with registered reads.
module sgf_row_store #(
   parameter int MAX_WIDTH  = 2048,
   parameter int PIXEL_BITS = 24,
   parameter int XW         = 11
) (
   input  logic                  clock,
   input  logic                  rd_en,
   input  logic [XW-1:0]         rd_addr,
   input  logic [XW-1:0]         rd_addr_next,
   input  logic                  orig_wr_en,
   input  logic [PIXEL_BITS-1:0] orig_wr_data,
   input  logic                  proc_wr_en,
   input  logic [XW-1:0]         proc_wr_addr,
   input  logic [PIXEL_BITS-1:0] proc_wr_data,
   output logic [PIXEL_BITS-1:0] center_ff,
   output logic [PIXEL_BITS-1:0] right_ff,
   output logic [PIXEL_BITS-1:0] up_ff
);
   import sgf_pkg::*;

   logic [PIXEL_BITS-1:0] original_mem [MAX_WIDTH];
   logic [PIXEL_BITS-1:0] processed_mem [MAX_WIDTH];

   // original row: read old contents, then overwrite the center column
   always_ff @(posedge clock) begin
      if (rd_en) begin
         center_ff <= original_mem[rd_addr];
         right_ff  <= original_mem[rd_addr_next];
      end
      if (orig_wr_en) begin
         original_mem[rd_addr] <= orig_wr_data;
      end
   end

   // processed row: read at the address stage, written back from the fill stage
   always_ff @(posedge clock) begin
      if (rd_en) begin
         up_ff <= processed_mem[rd_addr];
      end
      if (proc_wr_en) begin
         processed_mem[proc_wr_addr] <= proc_wr_data;
      end
   end

endmodule

/* rtl/sgf_fill_unit.sv */
// Hole detection and neighbour selection for one pixel.
module sgf_fill_unit #(
   parameter int CHANNEL_BITS = 8
) (
   input  sgf_pkg::fill_ctl_type      ctl,
   input  logic [3*CHANNEL_BITS-1:0]  center,
   input  logic [3*CHANNEL_BITS-1:0]  up,
   input  logic [3*CHANNEL_BITS-1:0]  down,
   input  logic [3*CHANNEL_BITS-1:0]  left,
   input  logic [3*CHANNEL_BITS-1:0]  right,
   output logic [3*CHANNEL_BITS-1:0]  result
);
   import sgf_pkg::*;

   localparam int PB = 3 * CHANNEL_BITS;

   logic [PB-1:0] avg_vert;
   logic [PB-1:0] avg_horz;

   // per-channel sum of truncated halves
   always_comb begin
      for (int c = 0; c < 3; c++) begin
         avg_vert[c*CHANNEL_BITS +: CHANNEL_BITS] =
            (up[c*CHANNEL_BITS +: CHANNEL_BITS] >> 1) +
            (down[c*CHANNEL_BITS +: CHANNEL_BITS] >> 1);
         avg_horz[c*CHANNEL_BITS +: CHANNEL_BITS] =
            (left[c*CHANNEL_BITS +: CHANNEL_BITS] >> 1) +
            (right[c*CHANNEL_BITS +: CHANNEL_BITS] >> 1);
      end
   end

   // vertical pair first, then horizontal pair, else keep the hole
   always_comb begin
      result = center;
      if (ctl.interior && (center == '0)) begin
         if ((up != '0) && (down != '0)) begin
            result = ctl.average_mode ? avg_vert : up;
         end else if ((left != '0) && (right != '0)) begin
            result = ctl.average_mode ? avg_horz : left;
         end
      end
   end

endmodule

/* rtl/sgf_result_queue.sv */
// Small result queue taking up to two transactions per cycle, one out per cycle while out_stall is low.
module sgf_result_queue #(
   parameter int PIXEL_BITS = 24
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   push0,
   input  logic [PIXEL_BITS-1:0]                  pixel0,
   input  sgf_pkg::rsp_flags_type                 flags0,
   input  logic                                   push1,
   input  logic [PIXEL_BITS-1:0]                  pixel1,
   input  sgf_pkg::rsp_flags_type                 flags1,
   output logic                                   out_valid,
   output logic [PIXEL_BITS-1:0]                  out_pixel,
   output sgf_pkg::rsp_flags_type                 out_flags,
   input  logic                                   out_stall,
   output logic [sgf_pkg::QUEUE_COUNT_BITS-1:0]   count
);
   import sgf_pkg::*;

   logic [PIXEL_BITS-1:0]       pixel_ff [QUEUE_DEPTH];
   rsp_flags_type               flags_ff [QUEUE_DEPTH];
   logic [QUEUE_PTR_BITS-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_PTR_BITS-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_COUNT_BITS-1:0] count_ff, count_in;
   logic [QUEUE_PTR_BITS-1:0]   second_ptr;
   logic                        pop;

   assign out_valid = (count_ff != '0);
   assign out_pixel = pixel_ff[rd_ptr_ff];
   assign out_flags = flags_ff[rd_ptr_ff];
   assign count     = count_ff;
   assign pop       = out_valid && !out_stall;

   // second push lands behind the first one if both are present
   assign second_ptr = wr_ptr_ff + QUEUE_PTR_BITS'(push0);

   // pointer and occupancy update
   always_comb begin
      wr_ptr_in = wr_ptr_ff + QUEUE_PTR_BITS'(push0) + QUEUE_PTR_BITS'(push1);
      rd_ptr_in = rd_ptr_ff + QUEUE_PTR_BITS'(pop);
      count_in  = count_ff + QUEUE_COUNT_BITS'(push0) + QUEUE_COUNT_BITS'(push1)
                  - QUEUE_COUNT_BITS'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (push0) begin
         pixel_ff[wr_ptr_ff] <= pixel0;
         flags_ff[wr_ptr_ff] <= flags0;
      end
      if (push1) begin
         pixel_ff[second_ptr] <= pixel1;
         flags_ff[second_ptr] <= flags1;
      end
   end

endmodule

/* rtl/single_pixel_gap_fill_core.sv */
// Single-pixel gap fill core: raster pixel stream in, filled stream out one row late.
// Order: an accepted pixel of row y>0 passes the address stage, then the fill stage pushes pixel (y-1,x) to the queue.
// Throughput: one pixel per clock while req_stall is low; in the last row each pixel gives two results,
// so the single output port then sets the pace.
// Reset: counters to the frame origin, CSRs to 640x480 copy mode; the row stores are
// not cleared and only hold valid data once the first row of a frame has passed.
module single_pixel_gap_fill_core #(
   parameter int MAX_WIDTH    = 2048,
   parameter int CHANNEL_BITS = 8
) (
   input  logic                                clock,
   input  logic                                reset,
   // pixel input
   input  logic                                req_valid,
   output logic                                req_stall,
   input  logic [3*CHANNEL_BITS-1:0]           req_pixel_in,
   // result output
   output logic                                rsp_valid,
   input  logic                                rsp_stall,
   output logic [3*CHANNEL_BITS-1:0]           rsp_pixel_out,
   output logic                                rsp_last_of_run,
   output logic                                rsp_frame_end,
   // CSR write port
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [sgf_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  logic [sgf_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import sgf_pkg::*;

   localparam int PB = 3 * CHANNEL_BITS;
   localparam int XW = $clog2(MAX_WIDTH);
   localparam int WW = ($clog2(MAX_WIDTH + 1) > DIM_BITS) ? $clog2(MAX_WIDTH + 1) : DIM_BITS;

   // CSRs
   logic [DIM_BITS-1:0] frame_width_ff;
   logic [DIM_BITS-1:0] frame_height_ff;
   logic                average_mode_ff;

   // position counters
   logic [XW-1:0]       col_ff, col_in;
   logic [DIM_BITS-1:0] row_ff, row_in;

   // address stage
   logic [WW-1:0]       width_eff;
   logic [DIM_BITS-1:0] height_eff;
   logic [XW-1:0]       col_eff;
   logic [XW-1:0]       col_next_addr;
   logic [DIM_BITS-1:0] row_eff;
   logic                at_row_end;
   logic                at_last_row;
   logic                req_accept;
   fill_ctl_type        ctl_in;

   // fill stage
   fill_ctl_type        ctl_ff;
   logic [XW-1:0]       x_b_ff;
   logic [PB-1:0]       pix_b_ff;
   logic [PB-1:0]       left_ff;
   logic [PB-1:0]       center;
   logic [PB-1:0]       right;
   logic [PB-1:0]       up;
   logic [PB-1:0]       fill_result;

   // queue interface
   logic                        push0;
   logic                        push1;
   rsp_flags_type               flags0;
   rsp_flags_type               flags1;
   rsp_flags_type               out_flags;
   logic [QUEUE_COUNT_BITS-1:0] queue_count;
   logic [QUEUE_COUNT_BITS:0]   queue_need;

   // CSR writes
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_width_ff  <= DIM_BITS'(RESET_WIDTH);
         frame_height_ff <= DIM_BITS'(RESET_HEIGHT);
         average_mode_ff <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FRAME_WIDTH:  frame_width_ff  <= csr_data;
            CSR_FRAME_HEIGHT: frame_height_ff <= csr_data;
            CSR_AVERAGE_MODE: average_mode_ff <= csr_data[0];
            default: ;
         endcase
      end
   end

   // effective frame geometry
   always_comb begin
      if (frame_width_ff < DIM_BITS'(MIN_DIM)) begin
         width_eff = WW'(MIN_DIM);
      end else if (WW'(frame_width_ff) > WW'(MAX_WIDTH)) begin
         width_eff = WW'(MAX_WIDTH);
      end else begin
         width_eff = WW'(frame_width_ff);
      end
      height_eff = (frame_height_ff < DIM_BITS'(MIN_DIM)) ? DIM_BITS'(MIN_DIM) : frame_height_ff;
   end

   // position of this transaction and of the next one
   always_comb begin
      col_eff       = (WW'(col_ff) >= width_eff) ? '0 : col_ff;
      row_eff       = (row_ff >= height_eff) ? '0 : row_ff;
      at_row_end    = (WW'(col_eff) + WW'(1)) >= width_eff;
      at_last_row   = ({1'b0, row_eff} + (DIM_BITS+1)'(1)) >= {1'b0, height_eff};
      col_next_addr = (col_eff == XW'(MAX_WIDTH - 1)) ? '0 : col_eff + XW'(1);

      if (at_row_end) begin
         col_in = '0;
         row_in = at_last_row ? '0 : row_eff + DIM_BITS'(1);
      end else begin
         col_in = col_eff + XW'(1);
         row_in = row_eff;
      end

      ctl_in.valid        = req_accept;
      ctl_in.has_prev_row = (row_eff != '0);
      ctl_in.interior     = (row_eff >= DIM_BITS'(2)) && (col_eff != '0) && !at_row_end;
      ctl_in.last_row     = at_last_row;
      ctl_in.row_end      = at_row_end;
      ctl_in.average_mode = average_mode_ff;
   end

   // admit only when the queue can hold both results of everything in flight
   assign queue_need = (QUEUE_COUNT_BITS+1)'(queue_count)
                       + (ctl_ff.valid ? (QUEUE_COUNT_BITS+1)'(2) : '0)
                       + (QUEUE_COUNT_BITS+1)'(2);
   assign req_stall  = queue_need > (QUEUE_COUNT_BITS+1)'(QUEUE_DEPTH);
   assign req_accept = req_valid && !req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= '0;
         row_ff <= '0;
         ctl_ff <= '0;
      end else begin
         ctl_ff <= ctl_in;
         if (req_accept) begin
            col_ff <= col_in;
            row_ff <= row_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_accept) begin
         x_b_ff   <= col_eff;
         pix_b_ff <= req_pixel_in;
      end
   end

   // line buffers
   sgf_row_store #(
      .MAX_WIDTH  (MAX_WIDTH),
      .PIXEL_BITS (PB),
      .XW         (XW)
   ) u_row_store (
      .clock        (clock),
      .rd_en        (req_accept),
      .rd_addr      (col_eff),
      .rd_addr_next (col_next_addr),
      .orig_wr_en   (req_accept),
      .orig_wr_data (req_pixel_in),
      .proc_wr_en   (ctl_ff.valid && ctl_ff.has_prev_row),
      .proc_wr_addr (x_b_ff),
      .proc_wr_data (fill_result),
      .center_ff    (center),
      .right_ff     (right),
      .up_ff        (up)
   );

   // fill decision
   sgf_fill_unit #(
      .CHANNEL_BITS (CHANNEL_BITS)
   ) u_fill_unit (
      .ctl    (ctl_ff),
      .center (center),
      .up     (up),
      .down   (pix_b_ff),
      .left   (left_ff),
      .right  (right),
      .result (fill_result)
   );

   // left neighbour for the next column
   always_ff @(posedge clock) begin
      if (reset) begin
         left_ff <= '0;
      end else if (ctl_ff.valid && ctl_ff.has_prev_row) begin
         left_ff <= fill_result;
      end
   end

   // result transactions of the fill stage
   always_comb begin
      push0              = ctl_ff.valid && ctl_ff.has_prev_row;
      push1              = ctl_ff.valid && ctl_ff.last_row;
      flags0.last_of_run = !ctl_ff.last_row;
      flags0.frame_end   = 1'b0;
      flags1.last_of_run = 1'b1;
      flags1.frame_end   = ctl_ff.row_end;
   end

   sgf_result_queue #(
      .PIXEL_BITS (PB)
   ) u_result_queue (
      .clock     (clock),
      .reset     (reset),
      .push0     (push0),
      .pixel0    (fill_result),
      .flags0    (flags0),
      .push1     (push1),
      .pixel1    (pix_b_ff),
      .flags1    (flags1),
      .out_valid (rsp_valid),
      .out_pixel (rsp_pixel_out),
      .out_flags (out_flags),
      .out_stall (rsp_stall),
      .count     (queue_count)
   );

   assign rsp_last_of_run = out_flags.last_of_run;
   assign rsp_frame_end   = out_flags.frame_end;

   // checks
   a_queue_bound: assert property (@(posedge clock) disable iff (reset)
      queue_count <= QUEUE_COUNT_BITS'(QUEUE_DEPTH))
      else $error("result queue overflow");

   a_accept_to_fill: assert property (@(posedge clock) disable iff (reset)
      req_accept |=> ctl_ff.valid)
      else $error("accepted pixel did not reach the fill stage");

   a_frame_end_last: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_frame_end) |-> rsp_last_of_run)
      else $error("frame end without last of run");

   a_second_needs_first: assert property (@(posedge clock) disable iff (reset)
      push1 |-> push0)
      else $error("pass-through result without filled result");

endmodule
